[rtl/psr_pkg.sv]
`timescale 1ns / 1ps
// psr_pkg: payload, configuration and channel-state types for the PID speed regulator.
// Also holds register indexes, fixed-point limits and saturating arithmetic helpers.
// No dependencies.
package psr_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRESTART_DRIVE = 3'd4;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  // 255.0 in s16.15
  localparam logic signed [31:0] FX_255 = 32'sd8355840;

  typedef struct packed {
    logic              motor_sel;
    logic signed [31:0] target_speed;
    logic signed [31:0] measured_speed;
  } in_item_t;

  typedef struct packed {
    logic              motor_tag;
    logic signed [23:0] drive;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] gain_prop;
    logic signed [31:0] gain_integ;
    logic signed [31:0] gain_deriv;
    logic [30:0]        integ_limit;
    logic [22:0]        prestart_drive;
  } cfg_t;

  typedef struct packed {
    logic signed [23:0] drive;
    logic signed [31:0] integ;
    logic signed [31:0] last_err;
  } chan_state_t;

  function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) begin
      return s[32] ? S32_MIN : S32_MAX;
    end
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_sub32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) - 33'(b);
    if (s[32] != s[31]) begin
      return s[32] ? S32_MIN : S32_MAX;
    end
    return s[31:0];
  endfunction

  // floor(a*b / 2^15), saturated to 32 bits
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [48:0] q;
    p = 64'(a) * 64'(b);
    q = p[63:15];
    if (q > 49'sd2147483647) begin
      return S32_MAX;
    end else if (q < -49'sd2147483648) begin
      return S32_MIN;
    end
    return q[31:0];
  endfunction

endpackage

[rtl/psr_chan_store.sv]
`timescale 1ns / 1ps
// psr_chan_store: per-channel drive, integral and previous-error registers.
// Depends on psr_pkg for chan_state_t.
module psr_chan_store #(
  parameter int CHANNELS = 2,
  parameter int CH_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CH_W-1:0]       ch,
  input  logic                  wr_en,
  input  psr_pkg::chan_state_t  wr_state,
  output psr_pkg::chan_state_t  rd_state
);
  import psr_pkg::*;

  chan_state_t store [CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        store[i] <= '0;
      end
    end else if (wr_en) begin
      store[ch] <= wr_state;
    end
  end

  assign rd_state = store[ch];

endmodule

[rtl/psr_datapath.sv]
`timescale 1ns / 1ps
// psr_datapath: one PID update of a channel: integral clamp, three gain products,
// saturating sums and drive clamp. Depends on psr_pkg.
module psr_datapath (
  input  psr_pkg::cfg_t         cfg,
  input  psr_pkg::in_item_t     item,
  input  logic signed [31:0]    err,
  input  psr_pkg::chan_state_t  cur,
  output psr_pkg::chan_state_t  nxt
);
  import psr_pkg::*;

  logic signed [31:0] prev;
  logic signed [31:0] derr;
  logic signed [31:0] integ_sum;
  logic signed [31:0] lim_pos;
  logic signed [31:0] lim_neg;
  logic signed [31:0] integ;
  logic               tgt_pos;
  logic               tgt_zero;
  logic signed [31:0] drv_base;
  logic signed [31:0] p_term;
  logic signed [31:0] i_term;
  logic signed [31:0] d_term;
  logic signed [31:0] pid_sum;
  logic signed [31:0] drv_sum;
  logic signed [31:0] drv;

  always_comb begin
    prev      = cur.last_err;
    derr      = sat_sub32(err, prev);
    integ_sum = sat_add32(cur.integ, err);
    lim_pos   = signed'({1'b0, cfg.integ_limit});
    lim_neg   = -lim_pos;
    if (integ_sum > lim_pos) begin
      integ = lim_pos;
    end else if (integ_sum < lim_neg) begin
      integ = lim_neg;
    end else begin
      integ = integ_sum;
    end
    // error changed sign: drop the integral
    if ((err > 0 && prev < 0) || (err < 0 && prev > 0)) begin
      integ = '0;
    end

    tgt_pos  = item.target_speed > 0;
    tgt_zero = item.target_speed == 0;
    if (tgt_pos && item.measured_speed == 0) begin
      drv_base = signed'({9'd0, cfg.prestart_drive});
    end else begin
      drv_base = 32'(cur.drive);
    end

    p_term  = fx_mul(cfg.gain_prop, err);
    i_term  = fx_mul(cfg.gain_integ, integ);
    d_term  = fx_mul(cfg.gain_deriv, derr);
    pid_sum = sat_add32(sat_add32(p_term, i_term), d_term);
    drv_sum = sat_add32(drv_base, pid_sum);

    if (tgt_zero) begin
      drv   = '0;
      integ = '0;
    end else if (tgt_pos) begin
      if (drv_sum > FX_255) begin
        drv = FX_255;
      end else if (drv_sum < 0) begin
        drv = '0;
      end else begin
        drv = drv_sum;
      end
    end else begin
      if (drv_sum < -FX_255) begin
        drv = -FX_255;
      end else if (drv_sum > 0) begin
        drv = '0;
      end else begin
        drv = drv_sum;
      end
    end

    nxt.drive    = drv[23:0];
    nxt.integ    = integ;
    nxt.last_err = err;
  end

endmodule

[rtl/pid_speed_regulator.sv]
`timescale 1ns / 1ps
// pid_speed_regulator: top level of the incremental PID speed regulator.
// Depends on psr_pkg, psr_chan_store and psr_datapath.
//
//  channel | valid        | stall        | payload          | direction
//  --------+--------------+--------------+------------------+----------
//  tick    | tick_valid   | tick_stall   | tick   (in_item) | in
//  result  | result_valid | result_stall | result (out_item)| out
//  config  | cfg_wr_en    | -            | cfg_index/data   | in
//
// One tick per cycle while the result side does not stall. A tick is registered on
// transfer, updated by the datapath against its channel's state once the result
// register can take it, and the result is registered at the end of that cycle.
// The channel state is written in the same edge that loads the result, so ticks on
// the same channel follow back to back. Reset clears config, channel state and valids.
// A stalled result holds; the tick register still fills, then tick_stall rises.
module pid_speed_regulator #(
  parameter int MOTOR_CHANNELS = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            tick_valid,
  output logic                            tick_stall,
  input  psr_pkg::in_item_t               tick,
  output logic                            result_valid,
  input  logic                            result_stall,
  output psr_pkg::out_item_t              result,
  input  logic                            cfg_wr_en,
  input  logic [psr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import psr_pkg::*;

  localparam int CH_W = (MOTOR_CHANNELS > 1) ? $clog2(MOTOR_CHANNELS) : 1;

  cfg_t               cfg;
  logic               stg_valid;
  in_item_t           stg_item;
  logic signed [31:0] stg_err;
  logic               advance;
  logic               accept;
  logic [CH_W-1:0]    ch;
  chan_state_t        cur_state;
  chan_state_t        nxt_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GAIN_PROP:      cfg.gain_prop      <= cfg_data;
        REG_GAIN_INTEG:     cfg.gain_integ     <= cfg_data;
        REG_GAIN_DERIV:     cfg.gain_deriv     <= cfg_data;
        REG_INTEG_LIMIT:    cfg.integ_limit    <= cfg_data[30:0];
        REG_PRESTART_DRIVE: cfg.prestart_drive <= cfg_data[22:0];
        default: begin
        end
      endcase
    end
  end

  assign advance    = stg_valid && (!result_valid || !result_stall);
  assign tick_stall = stg_valid && !advance;
  assign accept     = tick_valid && !tick_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (accept) begin
      stg_valid <= 1'b1;
    end else if (advance) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_item <= tick;
      stg_err  <= sat_sub32(tick.target_speed, tick.measured_speed);
    end
  end

  assign ch = (MOTOR_CHANNELS > 1) ? CH_W'(stg_item.motor_sel) : '0;

  psr_chan_store #(
    .CHANNELS (MOTOR_CHANNELS),
    .CH_W     (CH_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .ch       (ch),
    .wr_en    (advance),
    .wr_state (nxt_state),
    .rd_state (cur_state)
  );

  psr_datapath u_datapath (
    .cfg  (cfg),
    .item (stg_item),
    .err  (stg_err),
    .cur  (cur_state),
    .nxt  (nxt_state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.motor_tag <= stg_item.motor_sel;
      result.drive     <= nxt_state.drive;
    end
  end

`ifndef SYNTHESIS
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (32'(result.drive) <= FX_255 && 32'(result.drive) >= -FX_255))
    else $error("drive magnitude above 255");

  a_advance_loads: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("update did not produce a result");

  a_zero_target: assert property (@(posedge clk) disable iff (rst)
    (advance && stg_item.target_speed == 0) |=> (result.drive == 0))
    else $error("zero target gave nonzero drive");

  a_tag_echo: assert property (@(posedge clk) disable iff (rst)
    advance |=> (result.motor_tag == $past(stg_item.motor_sel)))
    else $error("result tag does not match its tick");
`endif

endmodule

[dv/pid_speed_regulator_tb.sv]
`timescale 1ns / 1ps
// pid_speed_regulator_tb: self-checking testbench for the PID speed regulator.
// A scoreboard class predicts each channel's drive from accepted ticks; depends on
// psr_pkg and the pid_speed_regulator RTL.
module pid_speed_regulator_tb;
  import psr_pkg::*;

  localparam longint FULL_HI = 64'sd2147483647;
  localparam longint FULL_LO = -64'sd2147483648;
  localparam longint DRIVE_MAX = FX_255;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 4;
  localparam int PHASE_TICKS = 270;
  localparam int RANDOM_TICKS = PHASES * PHASE_TICKS;

  class drive_scoreboard;
    longint kp, ki, kd, lim, pre;
    longint drive_mem[2];
    longint integ_mem[2];
    longint err_mem[2];
    out_item_t drive_q[$];
    int mismatches;
    int accepted;
    int checked;

    function new();
      kp = 0;
      ki = 0;
      kd = 0;
      lim = 0;
      pre = 0;
      foreach (drive_mem[i]) begin
        drive_mem[i] = 0;
        integ_mem[i] = 0;
        err_mem[i] = 0;
      end
      mismatches = 0;
      accepted = 0;
      checked = 0;
    endfunction

    function longint clip32(longint v);
      if (v > FULL_HI) return FULL_HI;
      if (v < FULL_LO) return FULL_LO;
      return v;
    endfunction

    // s16.15 product, floored back to 15 fraction bits
    function longint scale_mul(longint g, longint x);
      longint p;
      p = g * x;
      return clip32(p >>> 15);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GAIN_PROP: kp = longint'($signed(data));
        REG_GAIN_INTEG: ki = longint'($signed(data));
        REG_GAIN_DERIV: kd = longint'($signed(data));
        REG_INTEG_LIMIT: lim = longint'(data[30:0]);
        REG_PRESTART_DRIVE: pre = longint'(data[22:0]);
        default: ;
      endcase
    endfunction

    function void note_tick(in_item_t t);
      int ch;
      longint tgt, meas, prev, e, de, ig, dv, total;
      out_item_t want;
      ch = t.motor_sel;
      tgt = longint'($signed(t.target_speed));
      meas = longint'($signed(t.measured_speed));
      prev = err_mem[ch];
      e = clip32(tgt - meas);
      de = clip32(e - prev);
      ig = clip32(integ_mem[ch] + e);
      if (ig > lim) ig = lim;
      else if (ig < -lim) ig = -lim;
      // integral dropped when the error flips sign
      if ((e > 0 && prev < 0) || (e < 0 && prev > 0)) ig = 0;
      dv = drive_mem[ch];
      if (tgt > 0 && meas == 0) dv = pre;
      if (tgt == 0) begin
        dv = 0;
        ig = 0;
      end else begin
        total = clip32(scale_mul(kp, e) + scale_mul(ki, ig));
        total = clip32(total + scale_mul(kd, de));
        dv = clip32(dv + total);
        if (tgt > 0) begin
          if (dv > DRIVE_MAX) dv = DRIVE_MAX;
          else if (dv < 0) dv = 0;
        end else begin
          if (dv < -DRIVE_MAX) dv = -DRIVE_MAX;
          else if (dv > 0) dv = 0;
        end
      end
      drive_mem[ch] = dv;
      integ_mem[ch] = ig;
      err_mem[ch] = e;
      want.motor_tag = t.motor_sel;
      want.drive = dv[23:0];
      drive_q.push_back(want);
      accepted++;
    endfunction

    function void miss(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at %0t: %s", $time, msg);
    endfunction

    function void check_result(out_item_t r);
      out_item_t want;
      if (drive_q.size() == 0) begin
        miss($sformatf("unexpected result tag %0d drive %0d", r.motor_tag, $signed(r.drive)));
        return;
      end
      want = drive_q.pop_front();
      checked++;
      if (r.motor_tag !== want.motor_tag)
        miss($sformatf("motor_tag exp %0d got %0d", want.motor_tag, r.motor_tag));
      if (r.drive !== want.drive)
        miss($sformatf("drive (tag %0d) exp %0d got %0d", want.motor_tag,
                       $signed(want.drive), $signed(r.drive)));
    endfunction

    function int pending();
      return drive_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic tick_valid = 1'b0;
  logic tick_stall;
  in_item_t tick = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_item_t result;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  drive_scoreboard sb = new();
  int gap_pct = 32;
  int stall_pct = 63;
  bit hold_req = 1'b0;
  int aim[2] = '{0, 0};

  pid_speed_regulator dut (
    .clk(clk),
    .rst(rst),
    .tick_valid(tick_valid),
    .tick_stall(tick_stall),
    .tick(tick),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3000000;
    $display("pid_speed_regulator_tb NOT OK");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  function automatic logic [31:0] fx(int whole);
    return 32'(whole * 32768);
  endfunction

  function automatic int rand_speed();
    case ($urandom_range(9))
      0: return 0;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0000;
      3, 4: return int'($urandom);
      default: return int'($urandom_range(19660800)) - 9830400;
    endcase
  endfunction

  // mostly steady targets per channel with measured speed tracking them
  function automatic in_item_t next_tick();
    in_item_t t;
    int ch;
    int meas;
    ch = $urandom_range(1);
    if ($urandom_range(9) == 0) aim[ch] = rand_speed();
    case ($urandom_range(19))
      0, 1, 2: meas = 0;
      3, 4, 5, 6, 7: meas = rand_speed();
      default: meas = aim[ch] + int'($urandom_range(327680)) - 163840;
    endcase
    t.motor_sel = ch[0];
    t.target_speed = aim[ch];
    t.measured_speed = meas;
    return t;
  endfunction

  task automatic send_tick(input in_item_t t);
    while ($urandom_range(99) < gap_pct) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick <= t;
    tick_valid <= 1'b1;
    @(posedge clk);
    while (tick_stall) @(posedge clk);
    sb.note_tick(t);
  endtask

  task automatic send(input bit sel, input logic [31:0] tgt, input logic [31:0] meas);
    in_item_t t;
    t.motor_sel = sel;
    t.target_speed = tgt;
    t.measured_speed = meas;
    send_tick(t);
  endtask

  task automatic wait_idle();
    tick_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setting(input int p);
    case (p)
      0: begin
        write_reg(REG_GAIN_PROP, int'($urandom_range(524288)) - 262144);
        write_reg(REG_GAIN_INTEG, int'($urandom_range(524288)) - 262144);
        write_reg(REG_GAIN_DERIV, int'($urandom_range(524288)) - 262144);
        write_reg(REG_INTEG_LIMIT, $urandom_range(fx(1000)));
        write_reg(REG_PRESTART_DRIVE, $urandom_range(FX_255));
      end
      1: begin
        write_reg(REG_GAIN_PROP, 32'h7FFF_FFFF);
        write_reg(REG_GAIN_INTEG, 32'h8000_0000);
        write_reg(REG_GAIN_DERIV, 32'h7FFF_FFFF);
        write_reg(REG_INTEG_LIMIT, 32'h7FFF_FFFF);
        write_reg(REG_PRESTART_DRIVE, FX_255);
      end
      2: begin
        write_reg(REG_GAIN_PROP, 32'h8000_0000);
        write_reg(REG_GAIN_INTEG, 32'h7FFF_FFFF);
        write_reg(REG_GAIN_DERIV, 32'h8000_0000);
        write_reg(REG_INTEG_LIMIT, 32'h0);
        write_reg(REG_PRESTART_DRIVE, 32'h0);
      end
      default: begin
        write_reg(REG_GAIN_PROP, $urandom);
        write_reg(REG_GAIN_INTEG, $urandom);
        write_reg(REG_GAIN_DERIV, $urandom);
        write_reg(REG_INTEG_LIMIT, {1'b0, 31'($urandom)});
        write_reg(REG_PRESTART_DRIVE, $urandom_range(FX_255));
      end
    endcase
  endtask

  initial begin : main
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset gains: drive must stay at zero
    send(1'b0, fx(50), 32'h0);
    send(1'b1, fx(-50), fx(3));
    wait_idle();

    // writes past the register list are dropped
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
    send(1'b0, fx(60), 32'h0);
    wait_idle();

    write_reg(REG_GAIN_PROP, 32'd49152);
    write_reg(REG_GAIN_INTEG, 32'd8192);
    write_reg(REG_GAIN_DERIV, 32'd16384);
    write_reg(REG_INTEG_LIMIT, fx(200));
    write_reg(REG_PRESTART_DRIVE, fx(40));

    send(1'b0, fx(100), 32'h0);
    send(1'b0, fx(100), fx(20));
    send(1'b0, fx(100), fx(130));
    send(1'b1, fx(-80), 32'h0);
    send(1'b1, fx(-80), fx(-120));
    send(1'b1, 32'h0, fx(5));
    send(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
    send(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
    send(1'b1, 32'h8000_0000, 32'h8000_0000);
    send(1'b1, 32'h7FFF_FFFF, 32'h0);
    send(1'b0, 32'h1, 32'h0);
    send(1'b0, 32'hFFFF_FFFF, 32'h0);
    send(1'b1, fx(255), fx(254));
    send(1'b1, fx(255), fx(254));
    send(1'b0, 32'h0, 32'h0);
    repeat (4) send(1'b0, fx(300), fx(10));
    repeat (2) send(1'b1, fx(-300), fx(-10));

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      load_setting(p);
      for (int k = 0; k < PHASE_TICKS; k++) begin
        n = p * PHASE_TICKS + k;
        if (n < RANDOM_TICKS / 3) begin
          gap_pct = 32;
          stall_pct = 63;
        end else if (n < 2 * RANDOM_TICKS / 3) begin
          gap_pct = 63;
          stall_pct = 32;
        end else begin
          gap_pct = 0;
          stall_pct = 0;
        end
        if (n == 5 * RANDOM_TICKS / 6) hold_req = 1'b1;
        send_tick(next_tick());
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Run: %0d ticks on both channels over reset, directed and %0d random gain sets",
             sb.accepted, PHASES);
    $display("Run: %0d drive results checked, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("pid_speed_regulator_tb OK");
    end else begin
      $display("pid_speed_regulator_tb NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/psr_pkg.sv
rtl/psr_chan_store.sv
rtl/psr_datapath.sv
rtl/pid_speed_regulator.sv
dv/pid_speed_regulator_tb.sv
